FILE: sv/dstm_pkg.sv
package dstm_pkg;

   // Audio timing
   localparam int unsigned SAMPLE_RATE = 44100;
   localparam int unsigned NYQUIST     = SAMPLE_RATE / 2;

   // 65503 = round(65536 * 6.28 / (2*pi)): folds the 6.28 factor into a 16-bit turn
   localparam int unsigned TURN_SCALE = 65503;
   localparam int unsigned TONE_AMPL  = 50;

   localparam int unsigned FREQ_WIDTH   = 16;
   localparam int unsigned PHASE_WIDTH  = 16;
   localparam int unsigned TURN_WIDTH   = 16;
   localparam int unsigned SINE_WIDTH   = 7;   // -50..50
   localparam int unsigned SUM_WIDTH    = 9;
   localparam int unsigned SAMPLE_WIDTH = 8;

   // Shared divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
   localparam int unsigned DIV_WIDTH       = 32;
   localparam int unsigned DIVISOR_WIDTH   = 16;
   localparam int unsigned DIV_COUNT_WIDTH = $clog2(DIV_WIDTH);

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TONE_FREQ_A = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TONE_FREQ_B = 1'd1;

   localparam logic signed [SUM_WIDTH-1:0] CLIP_HIGH = 9'sd128;
   localparam logic signed [SUM_WIDTH-1:0] CLIP_LOW  = -9'sd127;

   // round(32768 * sin(k*pi/32)), k = 0..16
   function automatic logic [15:0] quarter_sine(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:    v = 16'd0;
         5'd1:    v = 16'd3212;
         5'd2:    v = 16'd6393;
         5'd3:    v = 16'd9512;
         5'd4:    v = 16'd12540;
         5'd5:    v = 16'd15447;
         5'd6:    v = 16'd18205;
         5'd7:    v = 16'd20788;
         5'd8:    v = 16'd23170;
         5'd9:    v = 16'd25330;
         5'd10:   v = 16'd27246;
         5'd11:   v = 16'd28899;
         5'd12:   v = 16'd30274;
         5'd13:   v = 16'd31357;
         5'd14:   v = 16'd32138;
         5'd15:   v = 16'd32610;
         default: v = 16'd32768;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/dstm_div.sv
module dstm_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [dstm_pkg::DIV_WIDTH-1:0]        dividend,
   input  logic [dstm_pkg::DIVISOR_WIDTH-1:0]    divisor,
   output logic                                  done,
   output logic [dstm_pkg::DIV_WIDTH-1:0]        quotient,
   output logic [dstm_pkg::DIVISOR_WIDTH-1:0]    remainder
);

   localparam logic [dstm_pkg::DIV_COUNT_WIDTH-1:0] LAST_STEP =
      dstm_pkg::DIV_COUNT_WIDTH'(dstm_pkg::DIV_WIDTH - 1);

   logic                                      busy_ff;
   logic                                      done_ff;
   logic [dstm_pkg::DIV_COUNT_WIDTH-1:0]      count_ff;
   logic [dstm_pkg::DIV_WIDTH-1:0]            work_ff, work_in;
   logic [dstm_pkg::DIVISOR_WIDTH-1:0]        rem_ff, rem_in;
   logic [dstm_pkg::DIVISOR_WIDTH-1:0]        divisor_ff;
   logic [dstm_pkg::DIVISOR_WIDTH:0]          shifted;
   logic [dstm_pkg::DIVISOR_WIDTH:0]          diff;
   logic                                      ge;

   // Restoring step: work_ff shifts dividend bits out the top, quotient bits in the bottom
   always_comb begin
      shifted = {rem_ff, work_ff[dstm_pkg::DIV_WIDTH-1]};
      diff    = shifted - {1'b0, divisor_ff};
      ge      = shifted >= {1'b0, divisor_ff};
      rem_in  = ge ? diff[dstm_pkg::DIVISOR_WIDTH-1:0]
                   : shifted[dstm_pkg::DIVISOR_WIDTH-1:0];
      work_in = {work_ff[dstm_pkg::DIV_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         work_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/dstm_sine.sv
module dstm_sine (
   input  logic                                       clock,
   input  logic [dstm_pkg::TURN_WIDTH-1:0]            turn,
   output logic signed [dstm_pkg::SINE_WIDTH-1:0]     sine
);

   logic [14:0]                                   x_mirror;
   logic [4:0]                                    idx_ff;
   logic [9:0]                                    frac_ff;
   logic                                          neg1_ff, neg2_ff;
   logic [15:0]                                   base;
   logic [15:0]                                   upper;
   logic [15:0]                                   delta;
   logic [25:0]                                   interp;
   logic [15:0]                                   s_ff, s_in;
   logic [21:0]                                   scaled;
   logic [dstm_pkg::SINE_WIDTH-1:0]               mag;
   logic signed [dstm_pkg::SINE_WIDTH-1:0]        sine_ff, sine_in;

   // Stage 1: quadrant fold
   always_comb begin
      if (turn[14])
         x_mirror = 15'd16384 - {1'b0, turn[13:0]};
      else
         x_mirror = {1'b0, turn[13:0]};
   end

   // Stage 2: table lookup with linear interpolation
   always_comb begin
      base   = dstm_pkg::quarter_sine(idx_ff);
      upper  = dstm_pkg::quarter_sine(idx_ff + 5'd1);
      delta  = upper - base;
      interp = 26'(delta) * 26'(frac_ff);
      if (idx_ff[4])
         s_in = 16'd32768;
      else
         s_in = base + interp[25:10];
   end

   // Stage 3: amplitude scale and sign
   always_comb begin
      scaled  = 22'(dstm_pkg::TONE_AMPL) * 22'(s_ff);
      mag     = scaled[21:15];
      sine_in = neg2_ff ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      idx_ff  <= x_mirror[14:10];
      frac_ff <= x_mirror[9:0];
      neg1_ff <= turn[15];
      s_ff    <= s_in;
      neg2_ff <= neg1_ff;
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

FILE: sv/dual_sine_tone_mixer.sv
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | req_sample_request
// rsp     | out       | rsp_valid/stall   | rsp_mixed_sample
// csr     | in        | csr_write_enable  | csr_index, csr_write_data
//
// One shared 32-step restoring divider does all the arithmetic that needs division:
// per live channel it runs three times (period, turn angle, next phase); a silent
// channel only passes through the check state. The result is loaded in ST_FINISH
// once the output register is free, and the sequencer then returns to idle.
// A request with sample_request low is taken and yields no transfer.
// Synchronous reset clears frequencies, phases and handshake state.
// The result sits in an output register, so a new request is taken while it is stalled.
module dual_sine_tone_mixer (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_sample_request,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic signed [dstm_pkg::SAMPLE_WIDTH-1:0]    rsp_mixed_sample,
   input  logic                                        csr_write_enable,
   input  logic [dstm_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [dstm_pkg::FREQ_WIDTH-1:0]             csr_write_data
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CHECK      = 6'b000010,
      ST_DIV_PERIOD = 6'b000100,
      ST_DIV_TURN   = 6'b001000,
      ST_DIV_NEXT   = 6'b010000,
      ST_FINISH     = 6'b100000
   } state_type;

   state_type                                     state_ff, state_in;
   logic                                          chan_ff, chan_in;
   logic [dstm_pkg::FREQ_WIDTH-1:0]               freq_a_ff, freq_b_ff;
   logic [dstm_pkg::PHASE_WIDTH-1:0]              phase_a_ff, phase_b_ff;
   logic [dstm_pkg::DIVISOR_WIDTH-1:0]            period_ff;
   logic [dstm_pkg::TURN_WIDTH-1:0]               turn_ff;
   logic signed [dstm_pkg::SUM_WIDTH-1:0]         sum_ff;
   logic                                          rsp_valid_ff;
   logic signed [dstm_pkg::SAMPLE_WIDTH-1:0]      rsp_sample_ff;

   logic [dstm_pkg::FREQ_WIDTH-1:0]               cur_freq;
   logic [dstm_pkg::PHASE_WIDTH-1:0]              cur_phase;
   logic [dstm_pkg::PHASE_WIDTH:0]                phase_inc;
   logic                                          silent;
   logic                                          accept;
   logic                                          load_rsp;
   logic                                          div_start;
   logic [dstm_pkg::DIV_WIDTH-1:0]                div_dividend;
   logic [dstm_pkg::DIVISOR_WIDTH-1:0]            div_divisor;
   logic                                          div_done;
   logic [dstm_pkg::DIV_WIDTH-1:0]                div_quotient;
   logic [dstm_pkg::DIVISOR_WIDTH-1:0]            div_remainder;
   logic signed [dstm_pkg::SINE_WIDTH-1:0]        sine;
   logic signed [dstm_pkg::SUM_WIDTH-1:0]         clipped;

   dstm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   dstm_sine u_sine (
      .clock (clock),
      .turn  (turn_ff),
      .sine  (sine)
   );

   assign cur_freq  = chan_ff ? freq_b_ff : freq_a_ff;
   assign cur_phase = chan_ff ? phase_b_ff : phase_a_ff;
   assign phase_inc = {1'b0, cur_phase} + 1'b1;
   assign silent    = (cur_freq == '0) ||
                      (cur_freq > dstm_pkg::FREQ_WIDTH'(dstm_pkg::NYQUIST));
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (sum_ff > dstm_pkg::CLIP_HIGH)
         clipped = dstm_pkg::CLIP_HIGH;
      else if (sum_ff < dstm_pkg::CLIP_LOW)
         clipped = dstm_pkg::CLIP_LOW;
      else
         clipped = sum_ff;
   end

   // Divider operand select per sequencer step
   always_comb begin
      div_start    = 1'b0;
      div_dividend = dstm_pkg::DIV_WIDTH'(dstm_pkg::SAMPLE_RATE);
      div_divisor  = cur_freq;
      case (state_ff)
         ST_CHECK: begin
            div_start = !silent;
         end
         ST_DIV_PERIOD: begin
            div_start    = div_done;
            div_dividend = dstm_pkg::DIV_WIDTH'(cur_phase) *
                           dstm_pkg::DIV_WIDTH'(dstm_pkg::TURN_SCALE);
            div_divisor  = div_quotient[dstm_pkg::DIVISOR_WIDTH-1:0];
         end
         ST_DIV_TURN: begin
            div_start    = div_done;
            div_dividend = dstm_pkg::DIV_WIDTH'(phase_inc);
            div_divisor  = period_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            chan_in = 1'b0;
            if (accept && req_sample_request)
               state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (silent) begin
               chan_in  = 1'b1;
               state_in = chan_ff ? ST_FINISH : ST_CHECK;
            end else begin
               state_in = ST_DIV_PERIOD;
            end
         end
         ST_DIV_PERIOD: begin
            if (div_done)
               state_in = ST_DIV_TURN;
         end
         ST_DIV_TURN: begin
            if (div_done)
               state_in = ST_DIV_NEXT;
         end
         ST_DIV_NEXT: begin
            if (div_done) begin
               chan_in  = 1'b1;
               state_in = chan_ff ? ST_FINISH : ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (load_rsp)
               state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= 1'b0;
         freq_a_ff    <= '0;
         freq_b_ff    <= '0;
         phase_a_ff   <= '0;
         phase_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         if (csr_write_enable) begin
            case (csr_index)
               dstm_pkg::CSR_TONE_FREQ_A: freq_a_ff <= csr_write_data;
               dstm_pkg::CSR_TONE_FREQ_B: freq_b_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (state_ff == ST_DIV_NEXT && div_done) begin
            if (chan_ff)
               phase_b_ff <= div_remainder;
            else
               phase_a_ff <= div_remainder;
         end
         if (load_rsp)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE)
         sum_ff <= '0;
      else if (state_ff == ST_DIV_NEXT && div_done)
         sum_ff <= sum_ff + dstm_pkg::SUM_WIDTH'(sine);
      if (state_ff == ST_DIV_PERIOD && div_done)
         period_ff <= div_quotient[dstm_pkg::DIVISOR_WIDTH-1:0];
      // turn angle wraps modulo one full turn
      if (state_ff == ST_DIV_TURN && div_done)
         turn_ff <= div_quotient[dstm_pkg::TURN_WIDTH-1:0];
      if (load_rsp)
         rsp_sample_ff <= clipped[dstm_pkg::SAMPLE_WIDTH-1:0];
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = rsp_sample_ff;

endmodule

FILE: tb/dual_sine_tone_mixer_test.sv
module dual_sine_tone_mixer_test;

   localparam logic [dstm_pkg::FREQ_WIDTH-1:0] NYQ_TONE =
      dstm_pkg::FREQ_WIDTH'(dstm_pkg::NYQUIST);

   class tone_scoreboard;
      logic [dstm_pkg::FREQ_WIDTH-1:0]  freq_a;
      logic [dstm_pkg::FREQ_WIDTH-1:0]  freq_b;
      logic [dstm_pkg::PHASE_WIDTH-1:0] phase_a;
      logic [dstm_pkg::PHASE_WIDTH-1:0] phase_b;
      logic signed [dstm_pkg::SAMPLE_WIDTH-1:0] pending_samples[$];
      int unsigned quarter_wave[17];
      int errors;
      int checked;

      function new();
         quarter_wave = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                          25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
         freq_a  = '0;
         freq_b  = '0;
         phase_a = '0;
         phase_b = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_tone(logic [dstm_pkg::CSR_INDEX_WIDTH-1:0] index,
                             logic [dstm_pkg::FREQ_WIDTH-1:0] value);
         if (index == dstm_pkg::CSR_TONE_FREQ_A)
            freq_a = value;
         else if (index == dstm_pkg::CSR_TONE_FREQ_B)
            freq_b = value;
      endfunction

      function bit is_live(logic [dstm_pkg::FREQ_WIDTH-1:0] freq);
         return freq != 0 && freq <= dstm_pkg::NYQUIST;
      endfunction

      // signed sine level at 16-bit turn, interpolated from the quarter wave
      function int sine_level(logic [dstm_pkg::TURN_WIDTH-1:0] turn);
         logic [1:0]  quad;
         logic [14:0] x;
         int unsigned idx, frac, rise, s;
         int mag;
         quad = turn[15:14];
         x = {1'b0, turn[13:0]};
         if (quad[0])
            x = 15'd16384 - x;
         idx  = 32'(x[14:10]);
         frac = 32'(x[9:0]);
         if (idx >= 16) begin
            s = quarter_wave[16];
         end else begin
            rise = quarter_wave[idx+1] - quarter_wave[idx];
            s = quarter_wave[idx] + ((rise * frac) >> 10);
         end
         mag = int'((dstm_pkg::TONE_AMPL * s) >> 15);
         return quad[1] ? -mag : mag;
      endfunction

      function int tone_level(logic [dstm_pkg::FREQ_WIDTH-1:0] freq,
                              logic [dstm_pkg::PHASE_WIDTH-1:0] phase);
         longint unsigned period, turn;
         if (!is_live(freq))
            return 0;
         period = dstm_pkg::SAMPLE_RATE / freq;
         // a stale phase may overshoot the period; the turn simply wraps
         turn = (longint'(phase) * dstm_pkg::TURN_SCALE) / period;
         return sine_level(turn[dstm_pkg::TURN_WIDTH-1:0]);
      endfunction

      function logic [dstm_pkg::PHASE_WIDTH-1:0] next_phase(
            logic [dstm_pkg::FREQ_WIDTH-1:0] freq,
            logic [dstm_pkg::PHASE_WIDTH-1:0] phase);
         longint unsigned period, nxt;
         if (!is_live(freq))
            return phase;
         period = dstm_pkg::SAMPLE_RATE / freq;
         nxt = (longint'(phase) + 1) % period;
         return nxt[dstm_pkg::PHASE_WIDTH-1:0];
      endfunction

      // called once per accepted request transfer
      function void note_request(bit want);
         int sum;
         if (!want)
            return;
         sum = tone_level(freq_a, phase_a) + tone_level(freq_b, phase_b);
         phase_a = next_phase(freq_a, phase_a);
         phase_b = next_phase(freq_b, phase_b);
         if (sum > dstm_pkg::CLIP_HIGH)
            sum = dstm_pkg::CLIP_HIGH;
         if (sum < dstm_pkg::CLIP_LOW)
            sum = dstm_pkg::CLIP_LOW;
         pending_samples.push_back(sum[dstm_pkg::SAMPLE_WIDTH-1:0]);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_sample(logic signed [dstm_pkg::SAMPLE_WIDTH-1:0] got);
         logic signed [dstm_pkg::SAMPLE_WIDTH-1:0] want;
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d arrived with none pending", got));
         end else begin
            want = pending_samples.pop_front();
            if (got !== want)
               report_mismatch($sformatf("sample #%0d: mixed_sample %0d, predicted %0d",
                                         checked, got, want));
         end
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_sample_request = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [dstm_pkg::SAMPLE_WIDTH-1:0] rsp_mixed_sample;
   logic csr_write_enable = 1'b0;
   logic [dstm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = dstm_pkg::CSR_TONE_FREQ_A;
   logic [dstm_pkg::FREQ_WIDTH-1:0] csr_write_data = '0;

   tone_scoreboard sb = new();
   bit sender_quiet = 1'b0;

   dual_sine_tone_mixer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_request (req_sample_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mixed_sample   (rsp_mixed_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_sample(rsp_mixed_sample);
   end

   // receiver: random stalls, one long hold-off, one stretch with no stalls
   initial begin
      int hold_left;
      bit held_off;
      hold_left = 0;
      held_off  = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && sb.checked >= 250) begin
            held_off  = 1'b1;
            hold_left = 2000;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (sb.checked >= 500 && sb.checked < 650) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 13);
         end
      end
   end

   task automatic send_request(input bit want);
      if (!sender_quiet && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_request <= want;
      do @(posedge clock); while (req_stall);
      sb.note_request(want);
   endtask

   // block must be idle: writes both tone registers on consecutive edges
   task automatic tune(input logic [dstm_pkg::FREQ_WIDTH-1:0] fa,
                       input logic [dstm_pkg::FREQ_WIDTH-1:0] fb);
      csr_write_enable <= 1'b1;
      csr_index <= dstm_pkg::CSR_TONE_FREQ_A;
      csr_write_data <= fa;
      @(posedge clock);
      sb.set_tone(dstm_pkg::CSR_TONE_FREQ_A, fa);
      csr_index <= dstm_pkg::CSR_TONE_FREQ_B;
      csr_write_data <= fb;
      @(posedge clock);
      sb.set_tone(dstm_pkg::CSR_TONE_FREQ_B, fb);
      csr_write_enable <= 1'b0;
   endtask

   // drain all pending samples, then wait with req_valid low before the next tune
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending_samples.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [dstm_pkg::FREQ_WIDTH-1:0] pick_tone();
      case ($urandom_range(9))
         0:       return '0;
         1:       return dstm_pkg::FREQ_WIDTH'($urandom_range(65535));
         2:       return dstm_pkg::FREQ_WIDTH'($urandom_range(dstm_pkg::NYQUIST + 1, 65535));
         3:       return dstm_pkg::FREQ_WIDTH'($urandom_range(1, 50));
         4:       return dstm_pkg::FREQ_WIDTH'($urandom_range(18000, dstm_pkg::NYQUIST));
         default: return dstm_pkg::FREQ_WIDTH'($urandom_range(1, dstm_pkg::NYQUIST));
      endcase
   endfunction

   initial begin
      int total, n;
      bit want;
      total = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // both silent after reset, plus an empty request
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      settle();
      tune(16'd440, 16'd1000);
      repeat (4) send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      // shortest period and just above Nyquist; A phase is stale here
      settle();
      tune(NYQ_TONE, NYQ_TONE + 1'b1);
      repeat (3) send_request(1'b1);
      // lowest tone and all-ones register
      settle();
      tune(16'd1, 16'hFFFF);
      repeat (3) send_request(1'b1);
      settle();
      tune(16'd20000, 16'd1);
      repeat (3) send_request(1'b1);
      settle();
      tune(16'd0, NYQ_TONE);
      repeat (2) send_request(1'b1);

      for (int p = 0; p < 7; p++) begin
         settle();
         if (p == 0)
            tune(16'd1, NYQ_TONE);
         else if (p == 3)
            tune(NYQ_TONE + 1'b1, NYQ_TONE);
         else
            tune(pick_tone(), pick_tone());
         n = 0;
         while (n < 100) begin
            want = ($urandom_range(99) < 90);
            sender_quiet = (total >= 300 && total < 450);
            send_request(want);
            if (want) begin
               n++;
               total++;
            end
         end
      end

      settle();
      if (sb.errors == 0 && sb.pending_samples.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #15000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
